### hw/rtl/mesh_vertex_normal_accumulator_macros.svh
// Assertion macros shared by the RTL of the vertex normal accumulator.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define MVNA_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("mvna assertion failed");

// The condition implies the consequence in the next cycle.
`define MVNA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("mvna assertion failed");

`endif

### hw/rtl/mvna_pkg.sv
// Types and constants of the vertex normal accumulator.
package mvna_pkg;

    // Item modes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_FACE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // Field and datapath widths.
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int COORD_W = 32;
    localparam int POS_W   = 3 * COORD_W;
    localparam int SUM_W   = 3 * COORD_W;
    localparam int NRM_W   = 16;
    localparam int EDGE_W  = 25;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int VEC_W   = 51;
    localparam int MAG_W   = 50;

    // Unit length in Q1.14.
    localparam logic [14:0] NORM_ONE = 15'd16384;

    typedef logic signed [NRM_W-1:0] t_norm;

endpackage

### hw/rtl/mvna_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mvna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator.
//
// Vertex positions (Q16.16) live in one RAM and per-vertex normal sums in a
// second; both have a registered read. One word is worked on at a time. A
// load is written to the position RAM as it is taken. A face fetches its
// three corners, scales the edges, forms the cross product on one shared
// 25x25 multiplier, normalizes it and then updates the three sums by
// read-modify-write. A read normalizes the sum of its vertex. Normalization
// is the common path: a range scaling, squaring on one multiplier, a
// bit-serial square root and three parallel restoring dividers. A clear, and
// also the period right after reset, sweeps the sum RAM one entry per cycle
// through all MAX_VERTICES entries, during which no word is taken;
// vertex_count may be written at any time. Errors return zero normals.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CNT_W-1:0]          i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_mode,
    input  logic [IDX_W-1:0]          i_vertex_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [IDX_W-1:0]          i_corner_a,
    input  logic [IDX_W-1:0]          i_corner_b,
    input  logic [IDX_W-1:0]          i_corner_c,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [IDX_W-1:0]          o_result_index,
    output logic signed [NRM_W-1:0]   o_normal_x,
    output logic signed [NRM_W-1:0]   o_normal_y,
    output logic signed [NRM_W-1:0]   o_normal_z
);

`include "mesh_vertex_normal_accumulator_macros.svh"

    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_EDGE, S_ESCALE, S_MUL, S_CROSS, S_RDCAP,
        S_NCHK, S_NSCALE, S_SQ, S_SQRT, S_DINIT, S_DIV, S_SIGN, S_SUM_RD,
        S_SUM_WR, S_EMIT
    } t_state;

    // Control registers.
    t_state           r_state;
    logic [3:0]       r_cnt;
    logic [AW-1:0]    r_clr_addr;
    logic [CNT_W-1:0] r_vertex_count;
    logic             r_out_valid;
    logic             r_is_face;

    // Item and datapath registers.
    logic [IDX_W-1:0]        r_ca, r_cb, r_cc;
    logic [POS_W-1:0]        r_pa, r_pb, r_pc;
    logic                    r_esign [6];
    logic [COORD_W-1:0]      r_emag [6];
    logic signed [PROD_W-1:0] r_prod [6];
    logic signed [VEC_W-1:0] r_vec [3];
    logic                    r_sign [3];
    logic [MAG_W-1:0]        r_mag [3];
    logic [59:0]             r_sqp;
    logic [61:0]             r_acc;
    logic [63:0]             r_x, r_res, r_bit;
    logic [30:0]             r_len;
    logic [31:0]             r_rem [3];
    logic [14:0]             r_low [3];
    logic [14:0]             r_q [3];
    t_norm                   r_n [3];
    logic [1:0]              r_status;
    logic [IDX_W-1:0]        r_res_index;
    logic [1:0]              r_o_status;
    logic [IDX_W-1:0]        r_o_index;
    t_norm                   r_o_nx, r_o_ny, r_o_nz;

    // Combinational values.
    logic [31:0]              lim;
    logic                     accept, out_free;
    logic                     ok_vi, ok_a, ok_b, ok_c;
    logic [IDX_W-1:0]         cur_corner;
    logic [POS_W-1:0]         pos_rd_data, sum_rd_data;
    logic                     pos_wr_en, sum_wr_en;
    logic [AW-1:0]            sum_wr_addr, sum_rd_addr;
    logic [SUM_W-1:0]         sum_wr_data;
    logic                     n_esign [6];
    logic [COORD_W-1:0]       n_emag [6];
    logic signed [EDGE_W-1:0] edge_s [6];
    logic signed [EDGE_W-1:0] mul_a, mul_b;
    logic                     n_sign [3];
    logic [MAG_W-1:0]         n_mag [3];
    logic                     edge_big, mag_zero, mag_ge30, mag_ge33, mag_lt26, mag_lt29;
    logic [29:0]              sq_op;
    logic [63:0]              sqrt_t;
    logic [44:0]              div_num [3];
    logic [32:0]              div_t [3];
    logic [31:0]              sum_new [3];

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[AW-1:0];
    endfunction

    // Saturating add of a Q1.14 normal to a 32-bit sum.
    function automatic logic [31:0] sat_add(input logic [31:0] s, input t_norm d);
        logic signed [32:0] r;
        r = $signed({s[31], s}) + 33'(d);
        if (r[32] != r[31]) begin
            return r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r[31:0];
    endfunction

    // Index checks against the active vertex count.
    assign lim = (32'(r_vertex_count) < 32'(MAX_VERTICES)) ?
                 32'(r_vertex_count) : 32'(MAX_VERTICES);
    assign ok_vi = 32'(i_vertex_index) < lim;
    assign ok_a  = 32'(i_corner_a) < lim;
    assign ok_b  = 32'(i_corner_b) < lim;
    assign ok_c  = 32'(i_corner_c) < lim;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Corner selected by the step counter.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    cur_corner = r_ca;
            2'd1:    cur_corner = r_cb;
            default: cur_corner = r_cc;
        endcase
    end

    // Memory controls.
    assign pos_wr_en   = accept && (i_mode == MODE_LOAD) && ok_vi;
    assign sum_rd_addr = (r_state == S_IDLE) ? to_addr(i_vertex_index) : to_addr(cur_corner);
    assign sum_wr_en   = (r_state == S_CLEAR) || (r_state == S_SUM_WR);
    assign sum_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : to_addr(cur_corner);

    always_comb begin
        sum_new[0] = sat_add(sum_rd_data[95:64], r_n[0]);
        sum_new[1] = sat_add(sum_rd_data[63:32], r_n[1]);
        sum_new[2] = sat_add(sum_rd_data[31:0], r_n[2]);
        sum_wr_data = (r_state == S_CLEAR) ? '0 : {sum_new[0], sum_new[1], sum_new[2]};
    end

    mvna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pos_wr_en),
        .i_wr_addr (to_addr(i_vertex_index)),
        .i_wr_data ({i_coord_x, i_coord_y, i_coord_z}),
        .i_rd_addr (to_addr(cur_corner)),
        .o_rd_data (pos_rd_data)
    );

    mvna_ram #(.WIDTH(SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sum_wr_en),
        .i_wr_addr (sum_wr_addr),
        .i_wr_data (sum_wr_data),
        .i_rd_addr (sum_rd_addr),
        .o_rd_data (sum_rd_data)
    );

    // Edge differences b-a and c-a as sign and magnitude.
    always_comb begin
        logic signed [32:0] d [6];
        d[0] = $signed({r_pb[95], r_pb[95:64]}) - $signed({r_pa[95], r_pa[95:64]});
        d[1] = $signed({r_pb[63], r_pb[63:32]}) - $signed({r_pa[63], r_pa[63:32]});
        d[2] = $signed({r_pb[31], r_pb[31:0]})  - $signed({r_pa[31], r_pa[31:0]});
        d[3] = $signed({r_pc[95], r_pc[95:64]}) - $signed({r_pa[95], r_pa[95:64]});
        d[4] = $signed({r_pc[63], r_pc[63:32]}) - $signed({r_pa[63], r_pa[63:32]});
        d[5] = $signed({r_pc[31], r_pc[31:0]})  - $signed({r_pa[31], r_pa[31:0]});
        edge_big = 1'b0;
        for (int i = 0; i < 6; i++) begin
            n_esign[i] = d[i][32];
            n_emag[i]  = d[i][32] ? 32'(-d[i]) : d[i][31:0];
            edge_big   = edge_big || (r_emag[i][31:24] != '0);
            edge_s[i]  = r_esign[i] ? -$signed({1'b0, r_emag[i][23:0]})
                                    : $signed({1'b0, r_emag[i][23:0]});
        end
    end

    // Operand selection of the shared cross product multiplier.
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin mul_a = edge_s[1]; mul_b = edge_s[5]; end
            3'd1:    begin mul_a = edge_s[2]; mul_b = edge_s[4]; end
            3'd2:    begin mul_a = edge_s[2]; mul_b = edge_s[3]; end
            3'd3:    begin mul_a = edge_s[0]; mul_b = edge_s[5]; end
            3'd4:    begin mul_a = edge_s[0]; mul_b = edge_s[4]; end
            default: begin mul_a = edge_s[1]; mul_b = edge_s[3]; end
        endcase
    end

    // Sign, magnitude and range tests of the vector being normalized.
    always_comb begin
        mag_zero = 1'b1;
        mag_ge30 = 1'b0;
        mag_ge33 = 1'b0;
        mag_lt26 = 1'b1;
        mag_lt29 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n_sign[i] = r_vec[i][VEC_W-1];
            n_mag[i]  = r_vec[i][VEC_W-1] ? MAG_W'(-r_vec[i]) : r_vec[i][MAG_W-1:0];
            mag_zero  = mag_zero && (r_mag[i] == '0);
            mag_ge30  = mag_ge30 || (r_mag[i][MAG_W-1:30] != '0);
            mag_ge33  = mag_ge33 || (r_mag[i][MAG_W-1:33] != '0);
            mag_lt26  = mag_lt26 && (r_mag[i][MAG_W-1:26] == '0);
            mag_lt29  = mag_lt29 && (r_mag[i][MAG_W-1:29] == '0);
        end
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_op = r_mag[0][29:0];
            2'd1:    sq_op = r_mag[1][29:0];
            default: sq_op = r_mag[2][29:0];
        endcase
    end

    assign sqrt_t = r_res + r_bit;

    // Dividend setup and one restoring step per component.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_num[i] = {1'b0, r_mag[i][29:0], 14'b0} + 45'(r_res[30:1]);
            div_t[i]   = {r_rem[i], r_low[i][14]};
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_cnt          <= '0;
            r_vertex_count <= '0;
            r_out_valid    <= 1'b0;
            r_is_face      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            // The output word is loaded when a result is issued and drops once taken.
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ca      <= i_corner_a;
                        r_cb      <= i_corner_b;
                        r_cc      <= i_corner_c;
                        r_cnt     <= '0;
                        r_is_face <= (i_mode == MODE_FACE);
                        for (int i = 0; i < 3; i++) r_n[i] <= '0;
                        r_status  <= ST_RANGE;
                        unique case (i_mode)
                            MODE_LOAD: begin
                                r_res_index <= i_vertex_index;
                                if (!ok_vi) r_state <= S_EMIT;
                            end
                            MODE_FACE: begin
                                if (!ok_a) begin
                                    r_res_index <= i_corner_a;
                                    r_state     <= S_EMIT;
                                end else if (!ok_b) begin
                                    r_res_index <= i_corner_b;
                                    r_state     <= S_EMIT;
                                end else if (!ok_c) begin
                                    r_res_index <= i_corner_c;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_state <= S_FETCH;
                                end
                            end
                            MODE_READ: begin
                                r_res_index <= i_vertex_index;
                                r_state     <= ok_vi ? S_RDCAP : S_EMIT;
                            end
                            MODE_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    case (r_cnt[1:0])
                        2'd1:    r_pa <= pos_rd_data;
                        2'd2:    r_pb <= pos_rd_data;
                        2'd3:    r_pc <= pos_rd_data;
                        default: ;
                    endcase
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[1:0] == 2'd3) r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int i = 0; i < 6; i++) begin
                        r_esign[i] <= n_esign[i];
                        r_emag[i]  <= n_emag[i];
                    end
                    r_state <= S_ESCALE;
                end
                S_ESCALE: begin
                    if (edge_big) begin
                        for (int i = 0; i < 6; i++) r_emag[i] <= r_emag[i] >> 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod[r_cnt[2:0]] <= mul_a * mul_b;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd5) r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_vec[0] <= VEC_W'(r_prod[0]) - VEC_W'(r_prod[1]);
                    r_vec[1] <= VEC_W'(r_prod[2]) - VEC_W'(r_prod[3]);
                    r_vec[2] <= VEC_W'(r_prod[4]) - VEC_W'(r_prod[5]);
                    r_state  <= S_NCHK;
                end
                S_RDCAP: begin
                    r_vec[0] <= VEC_W'($signed(sum_rd_data[95:64]));
                    r_vec[1] <= VEC_W'($signed(sum_rd_data[63:32]));
                    r_vec[2] <= VEC_W'($signed(sum_rd_data[31:0]));
                    r_state  <= S_NCHK;
                end
                S_NCHK: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sign[i] <= n_sign[i];
                        r_mag[i]  <= n_mag[i];
                    end
                    r_state <= S_NSCALE;
                end
                S_NSCALE: begin
                    r_cnt <= '0;
                    r_acc <= '0;
                    if (mag_zero) begin
                        // A degenerate face adds nothing; a zero sum reports.
                        r_status <= ST_ZERO;
                        r_state  <= r_is_face ? S_IDLE : S_EMIT;
                    end else if (mag_ge33) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 4;
                    end else if (mag_ge30) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (mag_lt26) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 4;
                    end else if (mag_lt29) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sqp <= sq_op * sq_op;
                    if (r_cnt != 4'd0) r_acc <= r_acc + {2'b0, r_sqp};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd3) begin
                        r_x     <= {2'b0, r_acc + {2'b0, r_sqp}};
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_x >= sqrt_t) begin
                        r_x   <= r_x - sqrt_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_len <= r_res[30:0];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= 32'(div_num[i][44:15]);
                        r_low[i] <= div_num[i][14:0];
                        r_q[i]   <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (div_t[i] >= {2'b0, r_len}) begin
                            r_rem[i] <= 32'(div_t[i] - {2'b0, r_len});
                            r_q[i]   <= {r_q[i][13:0], 1'b1};
                        end else begin
                            r_rem[i] <= div_t[i][31:0];
                            r_q[i]   <= {r_q[i][13:0], 1'b0};
                        end
                        r_low[i] <= r_low[i] << 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd14) r_state <= S_SIGN;
                end
                S_SIGN: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_q[i] > NORM_ONE) begin
                            r_n[i] <= r_sign[i] ? -t_norm'(NORM_ONE) : t_norm'(NORM_ONE);
                        end else begin
                            r_n[i] <= r_sign[i] ? -t_norm'(r_q[i]) : t_norm'(r_q[i]);
                        end
                    end
                    r_status <= ST_OK;
                    r_cnt    <= '0;
                    r_state  <= r_is_face ? S_SUM_RD : S_EMIT;
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_WR;
                end
                S_SUM_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_state <= (r_cnt == 4'd2) ? S_IDLE : S_SUM_RD;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_status  <= r_status;
                        r_o_index   <= r_res_index;
                        r_o_nx      <= r_n[0];
                        r_o_ny      <= r_n[1];
                        r_o_nz      <= r_n[2];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_result_index = r_o_index;
    assign o_normal_x     = r_o_nx;
    assign o_normal_y     = r_o_ny;
    assign o_normal_z     = r_o_nz;

    // An error result carries a zero normal.
    `MVNA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_normal_x == 0 && o_normal_y == 0 && o_normal_z == 0)
    // The x and z components of a good normal stay within unit range.
    `MVNA_ASSERT_NOW(a_norm_range, i_clk, i_rst_n, o_out_valid && o_status == ST_OK, o_normal_x >= -16'sd16384 && o_normal_x <= 16'sd16384 && o_normal_z >= -16'sd16384 && o_normal_z <= 16'sd16384)
    // The divider never starts on a zero length.
    `MVNA_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n, r_state == S_DINIT, r_res[30:0] != '0)
    // A pending result is never overwritten by a new one.
    `MVNA_ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_index))

endmodule

### sim/mesh_vertex_normal_accumulator_tb.sv
// Self-checking testbench for the mesh vertex normal accumulator.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator_tb;
    import mvna_pkg::*;

    localparam int NV             = 4096;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4300;
    localparam int RANDOM_WORDS   = 460;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         vi;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]         a;
        logic [IDX_W-1:0]         b;
        logic [IDX_W-1:0]         c;
    } t_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        t_norm            nx;
        t_norm            ny;
        t_norm            nz;
    } t_normal;

    typedef struct {
        bit               set_count;
        logic [CNT_W-1:0] count;
        t_word            w;
        bit               typed;
        t_normal          r;
    } t_step;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [CNT_W-1:0]          i_cfg_wr_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [1:0]                i_mode;
    logic [IDX_W-1:0]          i_vertex_index;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic signed [COORD_W-1:0] i_coord_z;
    logic [IDX_W-1:0]          i_corner_a;
    logic [IDX_W-1:0]          i_corner_b;
    logic [IDX_W-1:0]          i_corner_c;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_status;
    logic [IDX_W-1:0]          o_result_index;
    logic signed [NRM_W-1:0]   o_normal_x;
    logic signed [NRM_W-1:0]   o_normal_y;
    logic signed [NRM_W-1:0]   o_normal_z;

    mesh_vertex_normal_accumulator #(.MAX_VERTICES(NV)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the mesh state.
    logic signed [31:0] pos_x [NV];
    logic signed [31:0] pos_y [NV];
    logic signed [31:0] pos_z [NV];
    bit                 loaded [NV];
    int                 sum_x [NV];
    int                 sum_y [NV];
    int                 sum_z [NV];
    int unsigned        vertex_count;

    t_normal normals_due[$];
    int      mismatches;
    int      words_taken;
    longint  cycle_count;

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'h1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Scales a vector to a unit normal in Q1.14; returns 0 for a zero vector.
    function automatic bit unit_normal(input longint v0, input longint v1, input longint v2,
                                       output t_norm n0, output t_norm n1, output t_norm n2);
        longint          vv [3];
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        t_norm           nn [3];
        vv[0] = v0;
        vv[1] = v1;
        vv[2] = v2;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (vv[i] < 0) ? longint'(-vv[i]) : longint'(vv[i]);
            if (m[i] > mx) mx = m[i];
        end
        n0 = '0;
        n1 = '0;
        n2 = '0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'h1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'h1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            nn[i] = (vv[i] < 0) ? -t_norm'(q) : t_norm'(q);
        end
        n0 = nn[0];
        n1 = nn[1];
        n2 = nn[2];
        return 1'b1;
    endfunction

    function automatic int sat_add(input int s, input longint d);
        longint r;
        r = longint'(s) + d;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return int'(r);
    endfunction

    // Adds the unit normal of face a-b-c to the sums of its corners.
    function automatic void accumulate_face(input int a, input int b, input int c);
        longint          e [6];
        longint unsigned m [6];
        longint unsigned mx;
        longint          cx, cy, cz;
        t_norm           n0, n1, n2;
        int              corner [3];
        e[0] = longint'(pos_x[b]) - longint'(pos_x[a]);
        e[1] = longint'(pos_y[b]) - longint'(pos_y[a]);
        e[2] = longint'(pos_z[b]) - longint'(pos_z[a]);
        e[3] = longint'(pos_x[c]) - longint'(pos_x[a]);
        e[4] = longint'(pos_y[c]) - longint'(pos_y[a]);
        e[5] = longint'(pos_z[c]) - longint'(pos_z[a]);
        mx = 0;
        for (int i = 0; i < 6; i++) begin
            m[i] = (e[i] < 0) ? longint'(-e[i]) : longint'(e[i]);
            if (m[i] > mx) mx = m[i];
        end
        // Wide edges are shifted down together until they fit in 24 bits.
        while (mx >= (64'h1 << 24)) begin
            mx = mx >> 1;
            for (int i = 0; i < 6; i++) m[i] = m[i] >> 1;
        end
        for (int i = 0; i < 6; i++) e[i] = (e[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
        cx = e[1] * e[5] - e[2] * e[4];
        cy = e[2] * e[3] - e[0] * e[5];
        cz = e[0] * e[4] - e[1] * e[3];
        void'(unit_normal(cx, cy, cz, n0, n1, n2));
        corner[0] = a;
        corner[1] = b;
        corner[2] = c;
        for (int i = 0; i < 3; i++) begin
            sum_x[corner[i]] = sat_add(sum_x[corner[i]], longint'(n0));
            sum_y[corner[i]] = sat_add(sum_y[corner[i]], longint'(n1));
            sum_z[corner[i]] = sat_add(sum_z[corner[i]], longint'(n2));
        end
    endfunction

    function automatic int unsigned index_limit();
        return (vertex_count < NV) ? vertex_count : NV;
    endfunction

    // Applies one word to the shadow state; returns 1 when it yields a result.
    function automatic bit predict_normal(input t_word w, output t_normal r);
        int unsigned lim;
        lim = index_limit();
        r = '0;
        case (w.mode)
            MODE_LOAD: begin
                if (w.vi >= lim) begin
                    r.status = ST_RANGE;
                    r.idx    = w.vi;
                    return 1'b1;
                end
                pos_x[w.vi]  = w.x;
                pos_y[w.vi]  = w.y;
                pos_z[w.vi]  = w.z;
                loaded[w.vi] = 1'b1;
                return 1'b0;
            end
            MODE_FACE: begin
                r.status = ST_RANGE;
                if (w.a >= lim) begin
                    r.idx = w.a;
                    return 1'b1;
                end
                if (w.b >= lim) begin
                    r.idx = w.b;
                    return 1'b1;
                end
                if (w.c >= lim) begin
                    r.idx = w.c;
                    return 1'b1;
                end
                accumulate_face(w.a, w.b, w.c);
                return 1'b0;
            end
            MODE_READ: begin
                r.idx = w.vi;
                if (w.vi >= lim) begin
                    r.status = ST_RANGE;
                end else if (unit_normal(sum_x[w.vi], sum_y[w.vi], sum_z[w.vi],
                                         r.nx, r.ny, r.nz)) begin
                    r.status = ST_OK;
                end else begin
                    r.status = ST_ZERO;
                end
                return 1'b1;
            end
            default: begin
                for (int i = 0; i < NV; i++) begin
                    sum_x[i] = 0;
                    sum_y[i] = 0;
                    sum_z[i] = 0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Offers one word, waits for it to be taken and records what it should yield.
    task automatic send_word(input t_word w, input bit typed, input t_normal typed_r);
        t_normal pr;
        bit      has;
        bit      quiet;
        quiet = (words_taken >= 700) && (words_taken < 900);
        if (!quiet && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= w.mode;
        i_vertex_index <= w.vi;
        i_coord_x      <= w.x;
        i_coord_y      <= w.y;
        i_coord_z      <= w.z;
        i_corner_a     <= w.a;
        i_corner_b     <= w.b;
        i_corner_c     <= w.c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        has = predict_normal(w, pr);
        if (typed) normals_due.push_back(typed_r);
        else if (has) normals_due.push_back(pr);
        words_taken++;
    endtask

    // Writes vertex_count once the block has drained.
    task automatic set_vertex_count(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        vertex_count = value;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned lim;
        lim = index_limit();
        if (lim == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, ((lim < 64) ? lim : 64) - 1));
    endfunction

    function automatic logic [IDX_W-1:0] pick_loaded();
        logic [IDX_W-1:0] idx;
        idx = pick_index();
        for (int t = 0; t < 16; t++) begin
            if (idx < index_limit() && loaded[idx]) return idx;
            idx = pick_index();
        end
        return idx;
    endfunction

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 1 << 20)) - (1 << 19);
            2:       return (32'($urandom_range(0, 255)) - 128) <<< 16;
            default: return 32'($urandom_range(0, 1 << 28)) - (1 << 27);
        endcase
    endfunction

    // Random words, mostly well-formed meshes with some noise.
    task automatic random_phase(input int n);
        t_word       w;
        int unsigned roll;
        int unsigned lim;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            lim  = index_limit();
            w    = '0;
            w.x  = random_coord();
            w.y  = random_coord();
            w.z  = random_coord();
            w.vi = pick_index();
            w.a  = IDX_W'($urandom);
            w.b  = IDX_W'($urandom);
            w.c  = IDX_W'($urandom);
            if (roll < 3) begin
                w.mode = MODE_CLEAR;
            end else if (roll < 33) begin
                w.mode = MODE_LOAD;
            end else if (roll < 68) begin
                w.mode = MODE_FACE;
                w.a    = pick_loaded();
                if ($urandom_range(0, 9) != 0) begin
                    w.b = pick_loaded();
                    w.c = ($urandom_range(0, 19) == 0) ? w.a : pick_loaded();
                end
                // A face over valid corners may only touch loaded positions.
                if (w.a < lim && w.b < lim && w.c < lim &&
                    !(loaded[w.a] && loaded[w.b] && loaded[w.c])) begin
                    w.mode = MODE_LOAD;
                    w.vi   = loaded[w.a] ? (loaded[w.b] ? w.c : w.b) : w.a;
                end
            end else begin
                w.mode = MODE_READ;
                if ($urandom_range(0, 3) != 0) w.vi = pick_loaded();
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Result monitor.
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (normals_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual status %0d index %0d",
                         $time, o_status, o_result_index);
                mismatches++;
            end else begin
                e = normals_due.pop_front();
                check_field("status", e.status, o_status);
                check_field("result_index", e.idx, o_result_index);
                check_field("normal_x", e.nx, o_normal_x);
                check_field("normal_y", e.ny, o_normal_y);
                check_field("normal_z", e.nz, o_normal_z);
            end
        end
    end

    // Receiver stalls, one long hold-off and a quiet stretch.
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!held_once && words_taken >= 60) begin
            held_once = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else if (cycle_count > 60000 && cycle_count < 75000) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 23);
        end
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_step steps[$];

    initial begin
        logic [CNT_W-1:0] phase_counts [4];
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_out_stall    <= 1'b0;
        i_mode         <= MODE_LOAD;
        i_vertex_index <= '0;
        i_coord_x      <= '0;
        i_coord_y      <= '0;
        i_coord_z      <= '0;
        i_corner_a     <= '0;
        i_corner_b     <= '0;
        i_corner_c     <= '0;
        mismatches   = 0;
        words_taken  = 0;
        cycle_count  = 0;
        vertex_count = 0;
        for (int i = 0; i < NV; i++) begin
            loaded[i] = 1'b0;
            sum_x[i]  = 0;
            sum_y[i]  = 0;
            sum_z[i]  = 0;
        end

        // Directed words: empty mesh, then a small mesh with edge cases.
        steps = '{
            '{1, 13'd0, '0, 0, '0},
            '{0, 0, '{MODE_READ, 12'd0, 0, 0, 0, 0, 0, 0}, 1, '{ST_RANGE, 12'd0, 0, 0, 0}},
            '{0, 0, '{MODE_LOAD, 12'd4095, 1, 2, 3, 0, 0, 0}, 1,
              '{ST_RANGE, 12'd4095, 0, 0, 0}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 0, 0, 0}, 1, '{ST_RANGE, 12'd0, 0, 0, 0}},
            '{1, 13'd8, '0, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd0, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd1, 32'h10000, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd2, 0, 32'h10000, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd3, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd4, 32'h80000000, 32'h7fffffff, 32'h80000000,
              0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd5, 0, 0, 32'h10000, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd0, 0, 0, 0, 0, 0, 0}, 1, '{ST_ZERO, 12'd0, 0, 0, 0}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd0, 12'd1, 12'd2}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd0, 0, 0, 0, 0, 0, 0}, 1,
              '{ST_OK, 12'd0, 0, 0, 16'sd16384}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd0, 12'd0, 12'd1}, 0, '0},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd0, 12'd9, 12'd1}, 1,
              '{ST_RANGE, 12'd9, 0, 0, 0}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd8, 12'd1, 12'd2}, 1,
              '{ST_RANGE, 12'd8, 0, 0, 0}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd0, 12'd1, 12'd4095}, 1,
              '{ST_RANGE, 12'd4095, 0, 0, 0}},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd0, 12'd3, 12'd4}, 0, '0},
            '{0, 0, '{MODE_FACE, 12'd0, 0, 0, 0, 12'd2, 12'd1, 12'd5}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd3, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd4, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd1, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd7, 0, 0, 0, 0, 0, 0}, 1, '{ST_ZERO, 12'd7, 0, 0, 0}},
            '{0, 0, '{MODE_LOAD, 12'd8, 5, 6, 7, 0, 0, 0}, 1, '{ST_RANGE, 12'd8, 0, 0, 0}},
            '{0, 0, '{MODE_CLEAR, 12'd0, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd0, 0, 0, 0, 0, 0, 0}, 1, '{ST_ZERO, 12'd0, 0, 0, 0}},
            '{1, 13'd4096, '0, 0, '0},
            '{0, 0, '{MODE_LOAD, 12'd4095, -1, -1, -1, 0, 0, 0}, 0, '0},
            '{0, 0, '{MODE_READ, 12'd4095, 0, 0, 0, 0, 0, 0}, 1,
              '{ST_ZERO, 12'd4095, 0, 0, 0}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[i]) begin
            if (steps[i].set_count) set_vertex_count(steps[i].count);
            else send_word(steps[i].w, steps[i].typed, steps[i].r);
        end

        // Random phases across several mesh sizes, the extremes among them.
        phase_counts = '{13'd16, 13'd4096, 13'd8191, 13'd3};
        foreach (phase_counts[p]) begin
            set_vertex_count(phase_counts[p]);
            random_phase(RANDOM_WORDS);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
